FILE: sv/rff_pkg.sv
// Shared types, constants and the quarter-sine polynomial coefficients of the Fourier feature map.
// No dependencies; every other file of the block but rff_checker imports this package.
package rff_pkg;

    localparam int MAX_IN_DIM_DEF  = 16;
    localparam int MAX_OUT_DIM_DEF = 64;

    localparam logic [4:0]  DIM_IN_RESET  = 5'd16;
    localparam logic [6:0]  DIM_OUT_RESET = 7'd64;
    localparam logic [15:0] GAIN_RESET    = 16'd2896;

    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_OFFSET  = 2'd1;
    localparam logic [1:0] OP_ELEMENT = 2'd2;

    localparam logic [1:0] CFG_DIM_IN  = 2'd0;
    localparam logic [1:0] CFG_DIM_OUT = 2'd1;
    localparam logic [1:0] CFG_GAIN    = 2'd2;

    localparam logic [31:0] ONE_Q30 = 32'd1073741824;
    localparam logic [31:0] COEF1   = 32'd1686629713;
    localparam logic [31:0] COEF3   = 32'd693598668;
    localparam logic [31:0] COEF5   = 32'd85569306;
    localparam logic [31:0] COEF7   = 32'd5026998;
    localparam logic [31:0] COEF9   = 32'd172273;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_COS,
        ST_OUT
    } rff_state_t;

    // One phase word handed along the chain of feature cells.
    typedef struct packed {
        logic        vld;
        logic [5:0]  idx;
        logic        last;
        logic [23:0] phase;
    } rff_phase_t;

endpackage

FILE: sv/random_fourier_feature_map.sv
// Random Fourier feature map: gain*cos(2*pi*(W.x+b)) for each output feature.
// Depends on rff_pkg, rff_mac_cell and rff_cosine.
//
// Input words on s_axis carry weight loads, offset loads or vector elements.
// An element whose column is dim_in-1 starts a vector: a chain of MAX_IN_DIM
// multiply-accumulate cells, each holding one element, is fed one phase word
// per row, one row per cycle, and each cell adds a delay register and its
// output register. The phases then sit in a small buffer. The shared cosine
// unit takes one feature at a time and starts the next only once the output
// register is empty. No new word is accepted until the vector's last feature
// has left. Each feature leaves on m_axis with tlast on the final one; a
// stalled receiver holds the word in the output register and the cosine
// unit waits.
// Reset is synchronous; the stores are not cleared, and the user must write
// them before they are read, which the block itself does not enforce.
// Configuration writes on cfg_ are taken at any time and must only be made
// while the block is idle.
module random_fourier_feature_map #(
    parameter int MAX_IN_DIM  = rff_pkg::MAX_IN_DIM_DEF,
    parameter int MAX_OUT_DIM = rff_pkg::MAX_OUT_DIM_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // operation[1:0], row[7:2], column[11:8], value[29:12]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // feature_index[5:0], feature_value[21:6]
    output logic        m_axis_tlast   // last
);
    import rff_pkg::*;

    localparam int IW = (MAX_IN_DIM > 1) ? $clog2(MAX_IN_DIM) : 1;
    localparam int OW = (MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1;

    logic [1:0]  op;
    logic [5:0]  row;
    logic [3:0]  col;
    logic [17:0] val;
    assign op  = s_axis_tdata[1:0];
    assign row = s_axis_tdata[7:2];
    assign col = s_axis_tdata[11:8];
    assign val = s_axis_tdata[29:12];

    logic [4:0]  dim_in_reg;
    logic [6:0]  dim_out_reg;
    logic [15:0] gain_reg;
    logic [8:0]  ni;
    logic [10:0] no;

    assign ni = (dim_in_reg == 5'd0) ? 9'd1
              : ({4'd0, dim_in_reg} > 9'(MAX_IN_DIM)) ? 9'(MAX_IN_DIM) : {4'd0, dim_in_reg};
    assign no = (dim_out_reg == 7'd0) ? 11'd1
              : ({4'd0, dim_out_reg} > 11'(MAX_OUT_DIM)) ? 11'(MAX_OUT_DIM)
              : {4'd0, dim_out_reg};

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_in_reg  <= DIM_IN_RESET;
            dim_out_reg <= DIM_OUT_RESET;
            gain_reg    <= GAIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DIM_IN:  dim_in_reg  <= cfg_data[4:0];
                CFG_DIM_OUT: dim_out_reg <= cfg_data[6:0];
                CFG_GAIN:    gain_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    rff_state_t state_reg, state_next;
    logic s_acc;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;

    logic in_row_ok, in_col_ok, trigger;
    assign in_row_ok = ({26'd0, row} < 32'(MAX_OUT_DIM));
    assign in_col_ok = ({28'd0, col} < 32'(MAX_IN_DIM));
    assign trigger = s_acc && op == OP_ELEMENT && in_col_ok && ({5'd0, col} == ni - 9'd1);

    // Element registers, one per cell.
    logic signed [17:0] vec_reg [MAX_IN_DIM];
    always_ff @(posedge aclk) begin
        if (s_acc && op == OP_ELEMENT && in_col_ok) vec_reg[col[IW-1:0]] <= val;
    end

    // Offset memory and one basis bank per column.
    logic [15:0] off_mem [MAX_OUT_DIM];
    logic [15:0] off_rd;
    logic [OW-1:0] feed_row_reg;
    logic        feed_vld_reg, feed_last_reg;
    logic [10:0] feed_cnt_reg;

    always_ff @(posedge aclk) begin
        if (s_acc && op == OP_OFFSET && in_row_ok) off_mem[row[OW-1:0]] <= val[15:0];
        off_rd <= off_mem[feed_row_reg];
    end

    rff_phase_t chain [MAX_IN_DIM+1];
    logic [OW-1:0] row_pipe;
    logic          vld_pipe, last_pipe;

    // Delays the feed by the offset read so that the first phase word lines up.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_pipe <= 1'b0;
        end else begin
            vld_pipe <= feed_vld_reg;
        end
        last_pipe <= feed_last_reg;
        row_pipe  <= feed_row_reg;
    end

    assign chain[0].vld   = vld_pipe;
    assign chain[0].idx   = 6'(row_pipe);
    assign chain[0].last  = last_pipe;
    assign chain[0].phase = {off_rd, 8'd0};

    genvar g;
    generate
        for (g = 0; g < MAX_IN_DIM; g++) begin : g_cell
            logic [17:0] bank [MAX_OUT_DIM];
            logic [17:0] w_rd;
            logic signed [17:0] w_use, x_use;
            always_ff @(posedge aclk) begin
                if (s_acc && op == OP_WEIGHT && in_row_ok && {28'd0, col} == g)
                    bank[row[OW-1:0]] <= val;
                w_rd <= bank[OW'(chain[g].idx)];
            end
            // The weight is read at the row the word carries and meets it after the delay.
            assign w_use = (9'(g) < ni) ? $signed(w_rd) : 18'sd0;
            assign x_use = (9'(g) < ni) ? vec_reg[g] : 18'sd0;
            rff_phase_t dly;
            always_ff @(posedge aclk) dly <= chain[g];
            rff_mac_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .in_word(dly),
                .weight(w_use), .element(x_use), .out_word(chain[g+1])
            );
        end
    endgenerate

    // Phase buffer behind the chain, read through a register.
    logic [23:0] ph_mem [MAX_OUT_DIM];
    logic        ph_last [MAX_OUT_DIM];
    logic [10:0] ph_wr_reg, ph_rd_reg, ph_wr_d_reg;
    logic [23:0] ph_rd;
    logic        lst_rd;
    always_ff @(posedge aclk) begin
        if (chain[MAX_IN_DIM].vld) begin
            ph_mem[ph_wr_reg[OW-1:0]]  <= chain[MAX_IN_DIM].phase;
            ph_last[ph_wr_reg[OW-1:0]] <= chain[MAX_IN_DIM].last;
        end
        ph_rd  <= ph_mem[ph_rd_reg[OW-1:0]];
        lst_rd <= ph_last[ph_rd_reg[OW-1:0]];
    end

    logic        cos_start, cos_done;
    logic signed [15:0] cos_res;
    logic [5:0]  idx_reg;
    logic        cos_busy_reg, out_vld_reg, out_last_reg, cur_last_reg;
    logic [15:0] out_val_reg;
    logic [5:0]  out_idx_reg;

    // The delayed write count gives the registered read time to deliver the newly written phase.
    assign cos_start = (state_reg == ST_COS) && !cos_busy_reg && !out_vld_reg
                     && (ph_rd_reg < ph_wr_d_reg);

    rff_cosine u_cos (
        .aclk(aclk), .aresetn(aresetn), .start(cos_start), .phase(ph_rd),
        .gain(gain_reg), .done(cos_done), .result(cos_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (trigger) state_next = ST_ACC;
            ST_ACC:  if (feed_vld_reg && feed_last_reg) state_next = ST_COS;
            ST_COS:  if (out_vld_reg && m_axis_tready && out_last_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            feed_vld_reg <= 1'b0;
            feed_cnt_reg <= '0;
            ph_wr_reg    <= '0;
            ph_wr_d_reg  <= '0;
            ph_rd_reg    <= '0;
            cos_busy_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_wr_d_reg <= ph_wr_reg;
            if (trigger) begin
                feed_cnt_reg <= '0;
                ph_wr_reg    <= '0;
                ph_rd_reg    <= '0;
            end
            feed_vld_reg <= (state_reg == ST_ACC) && !(feed_vld_reg && feed_last_reg);
            if (feed_vld_reg) feed_cnt_reg <= feed_cnt_reg + 11'd1;
            if (chain[MAX_IN_DIM].vld) ph_wr_reg <= ph_wr_reg + 11'd1;
            if (cos_start) begin
                cos_busy_reg <= 1'b1;
                ph_rd_reg    <= ph_rd_reg + 11'd1;
            end
            if (cos_done) begin
                cos_busy_reg <= 1'b0;
                out_vld_reg  <= 1'b1;
            end else if (m_axis_tready) begin
                out_vld_reg  <= 1'b0;
            end
        end
        if (cos_start) begin
            idx_reg      <= 6'(ph_rd_reg);
            cur_last_reg <= lst_rd;
        end
        if (cos_done) begin
            out_val_reg  <= cos_res;
            out_idx_reg  <= idx_reg;
            out_last_reg <= cur_last_reg;
        end
    end

    // Feed counter drives the row and marks the final row.
    always_comb begin
        feed_row_reg  = feed_cnt_reg[OW-1:0];
        feed_last_reg = (feed_cnt_reg == no - 11'd1);
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_val_reg, out_idx_reg};
    assign m_axis_tlast  = out_last_reg;
endmodule

FILE: sv/rff_mac_cell.sv
// One multiply-accumulate cell: adds w*x modulo one turn to the phase it is handed.
// Depends on rff_pkg.
module rff_mac_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  rff_pkg::rff_phase_t in_word,
    input  logic signed [17:0] weight,
    input  logic signed [17:0] element,
    output rff_pkg::rff_phase_t out_word
);
    import rff_pkg::*;

    logic signed [35:0] prod;
    rff_phase_t out_reg;

    assign prod = weight * element;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else begin
            out_reg.vld <= in_word.vld;
        end
        out_reg.idx   <= in_word.idx;
        out_reg.last  <= in_word.last;
        out_reg.phase <= in_word.phase + prod[23:0];
    end

    assign out_word = out_reg;
endmodule

FILE: sv/rff_cosine.sv
// Sequential Horner evaluator of gain*cos(2*pi*phase), one multiply per cycle.
// Depends on rff_pkg.
module rff_cosine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [23:0]        phase,
    input  logic [15:0]        gain,
    output logic               done,
    output logic signed [15:0] result
);
    import rff_pkg::*;

    logic [3:0]  step_reg, step_next;
    logic        busy_reg;
    logic [31:0] a_reg, a2_reg, t_reg;
    logic        neg_reg;
    logic [15:0] mag_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] sh;
    logic [1:0]  q;
    logic [31:0] u;
    logic [31:0] prod;
    logic [16:0] magr;
    logic signed [15:0] res_reg;
    logic        done_reg;

    assign q = phase[23:22];
    assign u = {2'b00, phase[21:0], 8'd0};

    always_comb begin
        mul_a = a2_reg;
        mul_b = t_reg;
        case (step_reg)
            4'd0: begin mul_a = a_reg; mul_b = a_reg; end
            4'd5: begin mul_a = a_reg; mul_b = t_reg; end
            default: begin mul_a = a2_reg; mul_b = t_reg; end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign sh    = mul_p[61:30];
    assign magr  = sh[31:16] + {16'd0, sh[15]};
    assign prod  = gain * mag_reg + 32'd8192;
    assign step_next = step_reg + 4'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 4'd0;
            end else if (busy_reg) begin
                step_reg <= step_next;
                if (step_reg == 4'd6) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            a_reg   <= (q == 2'd0 || q == 2'd2) ? ONE_Q30 - u : u;
            neg_reg <= (q == 2'd1 || q == 2'd2);
            t_reg   <= COEF9;
        end else if (busy_reg) begin
            case (step_reg)
                4'd0: a2_reg <= sh;
                4'd1: t_reg <= COEF7 - sh;
                4'd2: t_reg <= COEF5 - sh;
                4'd3: t_reg <= COEF3 - sh;
                4'd4: t_reg <= COEF1 - sh;
                4'd5: mag_reg <= (magr > 17'd16384) ? 16'd16384 : magr[15:0];
                default: begin
                    if (neg_reg) begin
                        res_reg <= (prod[31:14] >= 18'd32768) ? 16'sh8000
                                 : $signed(16'd0 - prod[29:14]);
                    end else begin
                        res_reg <= (prod[31:14] > 18'd32767) ? 16'sh7fff
                                 : $signed(prod[29:14]);
                    end
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

FILE: sv/rff_checker.sv
// Port-level checks of the Fourier feature map, bound to the top level.
// Depends on random_fourier_feature_map.
module rff_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && s_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while results pending");
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("word after last of a vector");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
        else $error("padding bits set");
endmodule

bind random_fourier_feature_map rff_checker u_rff_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
